// ===== hw/rtl/gda_pkg.sv =====
// Shared types, constants and calendar helpers for the date-plus-days block.
`timescale 1ns / 1ps

package gda_pkg;

   localparam int START_YEAR_W  = 14;
   localparam int MONTH_W       = 4;
   localparam int DAY_W         = 5;
   localparam int DAYS_FIELD_W  = 20;
   // Wide enough for the largest start year plus the largest count in years.
   localparam int YEAR_W        = 15;
   localparam int LEN_W         = 9;
   localparam int YOE_W         = 9;

   localparam logic [YEAR_W-1:0]       YEAR_LIMIT     = 15'd9999;
   localparam logic [YEAR_W-1:0]       YEAR_FIELD_MAX = 15'd16383;
   localparam logic [START_YEAR_W-1:0] ERA_YEARS      = 14'd400;
   localparam logic [START_YEAR_W-1:0] ERA_LAST_YEAR  = 14'd399;
   localparam logic [LEN_W-1:0]        DAYS_YEAR      = 9'd365;
   localparam logic [LEN_W-1:0]        DAYS_LEAP_YEAR = 9'd366;
   localparam logic [MONTH_W-1:0]      MONTH_JAN      = 4'd1;
   localparam logic [MONTH_W-1:0]      MONTH_FEB      = 4'd2;
   localparam logic [MONTH_W-1:0]      MONTH_DEC      = 4'd12;

   typedef struct packed {
      logic [START_YEAR_W-1:0] start_year;
      logic [MONTH_W-1:0]      start_month;
      logic [DAY_W-1:0]        start_day;
      logic [DAYS_FIELD_W-1:0] days_to_add;
   } gda_req_type;

   typedef struct packed {
      logic [START_YEAR_W-1:0] result_year;
      logic [MONTH_W-1:0]      result_month;
      logic [DAY_W-1:0]        result_day;
      logic                    year_overflow;
   } gda_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_ALIGN,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } gda_state_type;

   // Leap test on the year within its 400-year era.
   function automatic logic is_leap(input logic [YOE_W-1:0] yoe);
      is_leap = (yoe[1:0] == 2'd0) && (yoe != 9'd100) && (yoe != 9'd200)
                && (yoe != 9'd300);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      month_len = len;
   endfunction

endpackage

// ===== hw/rtl/gregorian_date_add_days_top.sv =====
// Top level: Gregorian date plus a day count, one year or one month per cycle.
//
//  channel  | ports                         | direction | payload
//  request  | req_valid, req_ready, req_data | in        | start date and day count
//  response | rsp_valid, rsp_ready, rsp_data | out       | result date and overflow flag
//
// A transaction first finds the year within its era by taking off 400 years at a time,
// then steps months to the next January (11 steps and the exit compare at most),
// then takes one step per whole year of the count plus one (at most 2^DAY_COUNT_BITS / 365 + 1
// years), and then steps through the months of the last year: all through the single
// shared subtract-and-compare unit. If the count runs out while aligning, it ends there. The result
// is then valid from the next cycle. Reset is synchronous and returns the sequencer to
// idle. req_ready is high only while idle; the result is held until rsp_ready takes it.
`timescale 1ns / 1ps

module gregorian_date_add_days_top #(
   parameter int DAY_COUNT_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gda_pkg::gda_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gda_pkg::gda_rsp_type rsp_data
);
   import gda_pkg::*;

   localparam int CNT_W = (DAY_COUNT_BITS < DAYS_FIELD_W) ? DAY_COUNT_BITS : DAYS_FIELD_W;
   localparam int N_W   = CNT_W + 1;
   localparam int OP_W  = (N_W > START_YEAR_W) ? N_W : START_YEAR_W;

   gda_state_type state_ff, state_in;

   logic [YEAR_W-1:0]       y_ff, y_in;
   logic [START_YEAR_W-1:0] yoe_ff, yoe_in;
   logic [MONTH_W-1:0]      m_ff, m_in;
   logic [DAY_W-1:0]        d_ff, d_in;
   logic [N_W-1:0]          n_ff, n_in;

   logic [OP_W-1:0]         op_a, op_b, op_diff;
   logic                    op_ge;
   logic                    leap;
   logic [DAY_W-1:0]        mlen;
   logic [DAY_W-1:0]        d_clamp;
   logic [LEN_W-1:0]        step_len;
   logic [YEAR_W-1:0]       y_next;
   logic [START_YEAR_W-1:0] yoe_next;

   assign leap     = is_leap(yoe_ff[YOE_W-1:0]);
   assign mlen     = month_len(m_ff, leap);
   assign step_len = (state_ff == ST_YEAR) ? (leap ? DAYS_LEAP_YEAR : DAYS_YEAR)
                                           : LEN_W'(mlen);
   assign y_next   = y_ff + YEAR_W'(1);
   assign yoe_next = (yoe_ff == ERA_LAST_YEAR) ? '0 : yoe_ff + START_YEAR_W'(1);

   always_comb begin
      if (d_ff == '0) begin
         d_clamp = DAY_W'(1);
      end else if (d_ff > mlen) begin
         d_clamp = mlen;
      end else begin
         d_clamp = d_ff;
      end
   end

   assign op_a = (state_ff == ST_MOD) ? OP_W'(yoe_ff) : OP_W'(n_ff);
   assign op_b = (state_ff == ST_MOD) ? OP_W'(ERA_YEARS) : OP_W'(step_len);

   gda_step_unit #(
      .WIDTH (OP_W)
   ) u_step (
      .a    (op_a),
      .b    (op_b),
      .diff (op_diff),
      .ge   (op_ge)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      y_ff   <= y_in;
      yoe_ff <= yoe_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      n_ff   <= n_in;
   end

   always_comb begin
      state_in = state_ff;
      y_in     = y_ff;
      yoe_in   = yoe_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      n_in     = n_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               y_in   = YEAR_W'(req_data.start_year);
               yoe_in = req_data.start_year;
               if (req_data.start_month < MONTH_JAN) begin
                  m_in = MONTH_JAN;
               end else if (req_data.start_month > MONTH_DEC) begin
                  m_in = MONTH_DEC;
               end else begin
                  m_in = req_data.start_month;
               end
               d_in     = req_data.start_day;
               n_in     = N_W'(req_data.days_to_add[CNT_W-1:0]);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (op_ge) begin
               yoe_in = op_diff[START_YEAR_W-1:0];
            end else begin
               // fold the day of month into the count and stand on day 1
               n_in     = n_ff + N_W'(d_clamp - DAY_W'(1));
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (m_ff == MONTH_JAN) begin
               state_in = ST_YEAR;
            end else if (op_ge) begin
               n_in = op_diff[N_W-1:0];
               if (m_ff == MONTH_DEC) begin
                  m_in   = MONTH_JAN;
                  y_in   = y_next;
                  yoe_in = yoe_next;
               end else begin
                  m_in = m_ff + MONTH_W'(1);
               end
            end else begin
               d_in     = DAY_W'(n_ff[DAY_W-1:0]) + DAY_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_YEAR: begin
            if (op_ge) begin
               n_in   = op_diff[N_W-1:0];
               y_in   = y_next;
               yoe_in = yoe_next;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (op_ge && (m_ff != MONTH_DEC)) begin
               n_in = op_diff[N_W-1:0];
               m_in = m_ff + MONTH_W'(1);
            end else begin
               d_in     = DAY_W'(n_ff[DAY_W-1:0]) + DAY_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      rsp_data.result_year   = (y_ff > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX[START_YEAR_W-1:0]
                                                       : y_ff[START_YEAR_W-1:0];
      rsp_data.result_month  = m_ff;
      rsp_data.result_day    = d_ff;
      rsp_data.year_overflow = (y_ff > YEAR_LIMIT);
   end

endmodule

// ===== hw/rtl/gda_step_unit.sv =====
// Shared subtract-and-compare unit used by every sequencer step.
`timescale 1ns / 1ps

module gda_step_unit #(
   parameter int WIDTH = 21
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);
   logic [WIDTH:0] wide;

   assign wide = {1'b0, a} - {1'b0, b};
   assign diff = wide[WIDTH-1:0];
   assign ge   = ~wide[WIDTH];
endmodule

// ===== tb/gda_checker.sv =====
// Checker for the date-plus-days block: predicts each later date and compares responses.
`timescale 1ns / 1ps

module gda_checker #(
   parameter int DAY_COUNT_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  gda_pkg::gda_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  gda_pkg::gda_rsp_type rsp_data,
   output int                   fail_count,
   output int                   pending_count
);
   import gda_pkg::*;

   localparam longint unsigned ERA_DAYS = 146097;

   gda_rsp_type later_dates[$];

   // Exact date plus count, through a day number counted from a shifted epoch.
   function automatic gda_rsp_type predict_later_date(input gda_req_type item);
      longint unsigned y, m, d, n, len, yy, era, yoe, doy, doe, mp, day_no, ry, rm, rd;
      logic leap;
      gda_rsp_type res;
      y = item.start_year;
      m = item.start_month;
      d = item.start_day;
      n = item.days_to_add & ((64'd1 << DAY_COUNT_BITS) - 64'd1);
      // Clamp month and day into range before counting.
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         2:          len = leap ? 29 : 28;
         4, 6, 9, 11: len = 30;
         default:    len = 31;
      endcase
      if (d < 1) d = 1;
      if (d > len) d = len;
      // Date to day number, with March as the first month of the counting year.
      yy = y + 400 - ((m <= 2) ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mp = (m > 2) ? (m - 3) : (m + 9);
      doy = (153 * mp + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      day_no = era * ERA_DAYS + doe + n;
      // Day number back to a date.
      era = day_no / ERA_DAYS;
      doe = day_no - era * ERA_DAYS;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      rd = doy - (153 * mp + 2) / 5 + 1;
      rm = (mp < 10) ? (mp + 3) : (mp - 9);
      ry = yoe + era * 400 + ((rm <= 2) ? 1 : 0) - 400;
      res.result_year   = (ry > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX[START_YEAR_W-1:0]
                                                : ry[START_YEAR_W-1:0];
      res.result_month  = rm[MONTH_W-1:0];
      res.result_day    = rd[DAY_W-1:0];
      res.year_overflow = (ry > YEAR_LIMIT);
      return res;
   endfunction

   always @(posedge clock) begin
      int          mismatches;
      gda_rsp_type want;
      mismatches = 0;
      if (reset) begin
         later_dates.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (later_dates.size() == 0) begin
               $display("%0t: response with nothing expected: year %0d month %0d day %0d ovf %0b",
                        $time, rsp_data.result_year, rsp_data.result_month,
                        rsp_data.result_day, rsp_data.year_overflow);
               mismatches++;
            end else begin
               want = later_dates.pop_front();
               if (rsp_data.result_year !== want.result_year) begin
                  $display("%0t: result_year expected %0d, got %0d",
                           $time, want.result_year, rsp_data.result_year);
                  mismatches++;
               end
               if (rsp_data.result_month !== want.result_month) begin
                  $display("%0t: result_month expected %0d, got %0d",
                           $time, want.result_month, rsp_data.result_month);
                  mismatches++;
               end
               if (rsp_data.result_day !== want.result_day) begin
                  $display("%0t: result_day expected %0d, got %0d",
                           $time, want.result_day, rsp_data.result_day);
                  mismatches++;
               end
               if (rsp_data.year_overflow !== want.year_overflow) begin
                  $display("%0t: year_overflow expected %0b, got %0b",
                           $time, want.year_overflow, rsp_data.year_overflow);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            later_dates.push_back(predict_later_date(req_data));
         end
         fail_count    <= fail_count + mismatches;
         pending_count <= later_dates.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives date requests and back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
   import gda_pkg::*;

   localparam int DAY_COUNT_BITS = 20;
   localparam int SETTLE_CYCLES  = 3100;
   localparam int RANDOM_PER_PHASE = 50;
   localparam int NUM_PHASES     = 4;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   gda_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   gda_rsp_type rsp_data;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          rsp_stall_pct;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   gregorian_date_add_days_top #(
      .DAY_COUNT_BITS(DAY_COUNT_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   gda_checker #(
      .DAY_COUNT_BITS(DAY_COUNT_BITS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic gda_req_type make_date(input int unsigned y, input int unsigned m,
                                             input int unsigned d, input int unsigned n);
      gda_req_type item;
      item.start_year  = y[START_YEAR_W-1:0];
      item.start_month = m[MONTH_W-1:0];
      item.start_day   = d[DAY_W-1:0];
      item.days_to_add = n[DAYS_FIELD_W-1:0];
      return item;
   endfunction

   // Hold valid and payload until the transaction is taken.
   task automatic send_request(input gda_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin : timeout
      #80_000_000;
      $display("tb_top: errors");
      $finish;
   end

   initial begin : stimulus
      int          idle_by_phase[NUM_PHASES];
      int          stall_by_phase[NUM_PHASES];
      gda_req_type item;
      int unsigned pick;
      int unsigned mlen;
      idle_by_phase  = '{0, 56, 0, 9};
      stall_by_phase = '{0, 0, 56, 9};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, leap rules, clamping and overflow.
      send_request(make_date(0, 1, 1, 0));
      send_request(make_date(9999, 12, 31, 0));
      send_request(make_date(9999, 12, 31, 1));
      send_request(make_date(0, 2, 28, 1));
      send_request(make_date(1900, 2, 28, 1));
      send_request(make_date(2100, 2, 28, 1));
      send_request(make_date(2400, 2, 28, 1));
      send_request(make_date(2000, 2, 29, 365));
      send_request(make_date(1999, 12, 31, 1));
      send_request(make_date(0, 1, 1, 1048575));
      send_request(make_date(9999, 1, 1, 1048575));
      send_request(make_date(16383, 12, 31, 0));
      send_request(make_date(16383, 12, 31, 1048575));
      send_request(make_date(2023, 0, 15, 10));
      send_request(make_date(2023, 13, 15, 10));
      send_request(make_date(2023, 15, 31, 0));
      send_request(make_date(2024, 6, 0, 0));
      send_request(make_date(2024, 2, 31, 0));
      send_request(make_date(2023, 2, 31, 1));
      send_request(make_date(2023, 4, 31, 0));
      send_request(make_date(1600, 3, 1, 146097));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct = idle_by_phase[phase];
         rsp_stall_pct = stall_by_phase[phase];
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               item.start_year  = START_YEAR_W'($urandom_range(9999));
               item.start_month = MONTH_W'($urandom_range(12, 1));
               mlen = 32'(month_len(item.start_month,
                                    is_leap(YOE_W'(item.start_year % 400))));
               item.start_day   = ($urandom_range(3) == 0) ? DAY_W'(mlen)
                                                           : DAY_W'($urandom_range(mlen, 1));
            end else begin
               item.start_year  = START_YEAR_W'($urandom_range(16383));
               item.start_month = MONTH_W'($urandom_range(15));
               item.start_day   = DAY_W'($urandom_range(31));
            end
            // Keep most counts short; long counts take a sequencer step for every year.
            pick = $urandom_range(99);
            if (pick < 60) item.days_to_add = DAYS_FIELD_W'($urandom_range(1000));
            else if (pick < 80) item.days_to_add = DAYS_FIELD_W'($urandom_range(40000));
            else item.days_to_add = DAYS_FIELD_W'($urandom);
            send_request(item);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
